[rtl/vumw_pkg.sv]
// shared types and constants of the vector unpack mask/mode writer
`default_nettype none

package vumw_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_SET_ROW = 2'd1,
        CMD_SET_COL = 2'd2,
        CMD_START   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CODE_DATA    = 2'd0,
        CODE_ROW     = 2'd1,
        CODE_COLUMN  = 2'd2,
        CODE_PROTECT = 2'd3
    } chan_code_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_OFFSET = 2'd1,
        MODE_ACCUM  = 2'd2,
        MODE_COPY   = 2'd3
    } add_mode_t;

    typedef enum logic [2:0] {
        REG_WRITE_MASK  = 3'd0,
        REG_MASK_ENABLE = 3'd1,
        REG_ADD_MODE    = 3'd2,
        REG_CYCLE_CL    = 3'd3,
        REG_CYCLE_WL    = 3'd4
    } reg_index_t;

    localparam int LANES       = 4;
    localparam int WORD_W      = 32;
    localparam int QADDR_W     = 10;
    localparam int CNT_W       = 9;
    localparam int REG_INDEX_W = 3;

    typedef struct packed {
        chan_code_t code;
        add_mode_t  mode;
    } lane_ctrl_t;

    typedef struct packed {
        logic step;
        logic start;
    } seq_ctrl_t;

    typedef struct packed {
        logic [QADDR_W-1:0]              write_address;
        logic [LANES-1:0][WORD_W-1:0]    value;
        logic [LANES-1:0]                channel_enable;
        logic [LANES-1:0][WORD_W-1:0]    row_now;
    } result_t;

endpackage

`default_nettype wire

[rtl/vumw_if.sv]
// handshake channels for unpacked vectors and quadword writes
`default_nettype none

interface vumw_vec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [9:0]  start_address;
    logic [31:0] chan_x;
    logic [31:0] chan_y;
    logic [31:0] chan_z;
    logic [31:0] chan_w;

    modport source (
        output valid, command, start_address, chan_x, chan_y, chan_z, chan_w,
        input  ready
    );
    modport sink (
        input  valid, command, start_address, chan_x, chan_y, chan_z, chan_w,
        output ready
    );
endinterface

interface vumw_qw_if;
    logic        valid;
    logic        ready;
    logic [9:0]  write_address;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] out_w;
    logic [3:0]  channel_enable;
    logic [31:0] row_x_now;
    logic [31:0] row_y_now;
    logic [31:0] row_z_now;
    logic [31:0] row_w_now;

    modport source (
        output valid, write_address, out_x, out_y, out_z, out_w, channel_enable,
               row_x_now, row_y_now, row_z_now, row_w_now,
        input  ready
    );
    modport sink (
        input  valid, write_address, out_x, out_y, out_z, out_w, channel_enable,
               row_x_now, row_y_now, row_z_now, row_w_now,
        output ready
    );
endinterface

`default_nettype wire

[rtl/vector_unpack_mask_mode_writer_unit.sv]
// top level of the vector unpack mask/mode writer
//
// vec carries one unpacked four-channel vector word per handshake with a
// command: write vector, set row words, set column words, or start a block
// at a quadword address. Only write commands produce a word on qw: the
// quadword address, the four channel values, per-channel enables and the
// row words as left by that write.
// Configuration goes through wr_en / reg_index / wr_data; the user must write
// it only while the block is idle, which the block itself does not enforce.
// Writes to unknown indexes are ignored. Throughput: one vector word per cycle
// while the two-entry result buffer is not full; the lane datapath and address
// sequencer feed that buffer, which registers each result word for qw.
// When qw stalls, up to two results are held; vec.ready drops only when
// both are occupied and returns in the cycle after qw takes a word.
// Reset: row and column words, address and cycle count clear to zero,
// mask 0, masking off, add mode none, cl 1, wl 1; the buffer empties.
`default_nettype none

module vector_unpack_mask_mode_writer_unit #(
    parameter int MEM_QWORDS = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    vumw_vec_if.sink                               vec,
    vumw_qw_if.source                              qw,
    input  wire logic                              wr_en,
    input  wire logic [vumw_pkg::REG_INDEX_W-1:0]  reg_index,
    input  wire logic [vumw_pkg::WORD_W-1:0]       wr_data
);

    localparam int L = vumw_pkg::LANES;
    localparam int W = vumw_pkg::WORD_W;

    logic [W-1:0]        write_mask_reg;
    logic                mask_enable_reg;
    vumw_pkg::add_mode_t add_mode_reg;
    logic [7:0]          cycle_cl_reg;
    logic [7:0]          cycle_wl_reg;
    logic [W-1:0]        column_reg [L];

    logic                accept;
    logic                step;
    logic                set_row;
    logic                set_col;
    vumw_pkg::seq_ctrl_t seq_ctrl;
    logic [W-1:0]        ch [L];
    logic [vumw_pkg::QADDR_W-1:0] cur_address;
    logic [1:0]          row_sel;
    logic [7:0]          mask_byte;
    logic [W-1:0]        column_word;
    logic [W-1:0]        lane_value [L];
    logic                lane_on [L];
    logic [W-1:0]        lane_row [L];
    vumw_pkg::result_t   res;
    vumw_pkg::result_t   res_out;
    logic                buf_full;

    assign accept  = vec.valid && vec.ready;
    assign step    = accept && (vumw_pkg::cmd_t'(vec.command) == vumw_pkg::CMD_WRITE);
    assign set_row = accept && (vumw_pkg::cmd_t'(vec.command) == vumw_pkg::CMD_SET_ROW);
    assign set_col = accept && (vumw_pkg::cmd_t'(vec.command) == vumw_pkg::CMD_SET_COL);
    assign seq_ctrl.step  = step;
    assign seq_ctrl.start = accept && (vumw_pkg::cmd_t'(vec.command) == vumw_pkg::CMD_START);
    assign vec.ready = !buf_full;

    assign ch[0] = vec.chan_x;
    assign ch[1] = vec.chan_y;
    assign ch[2] = vec.chan_z;
    assign ch[3] = vec.chan_w;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_mask_reg  <= '0;
            mask_enable_reg <= 1'b0;
            add_mode_reg    <= vumw_pkg::MODE_NONE;
            cycle_cl_reg    <= 8'd1;
            cycle_wl_reg    <= 8'd1;
        end
        else if (wr_en)
        begin
            unique case (vumw_pkg::reg_index_t'(reg_index))
                vumw_pkg::REG_WRITE_MASK:  write_mask_reg  <= wr_data;
                vumw_pkg::REG_MASK_ENABLE: mask_enable_reg <= wr_data[0];
                vumw_pkg::REG_ADD_MODE:    add_mode_reg    <= vumw_pkg::add_mode_t'(wr_data[1:0]);
                vumw_pkg::REG_CYCLE_CL:    cycle_cl_reg    <= wr_data[7:0];
                vumw_pkg::REG_CYCLE_WL:    cycle_wl_reg    <= wr_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L; i++)
            begin
                column_reg[i] <= '0;
            end
        end
        else if (set_col)
        begin
            for (int i = 0; i < L; i++)
            begin
                column_reg[i] <= ch[i];
            end
        end
    end

    vumw_addr_seq #(
        .MEM_QWORDS (MEM_QWORDS)
    ) u_addr_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (seq_ctrl),
        .start_address (vec.start_address),
        .cycle_cl      (cycle_cl_reg),
        .cycle_wl      (cycle_wl_reg),
        .cur_address   (cur_address),
        .row_sel       (row_sel)
    );

    assign mask_byte   = write_mask_reg[row_sel*8 +: 8];
    assign column_word = column_reg[row_sel];

    for (genvar i = 0; i < L; i++)
    begin : g_lane
        vumw_pkg::lane_ctrl_t lane_ctrl;

        assign lane_ctrl.code = mask_enable_reg
                              ? vumw_pkg::chan_code_t'(mask_byte[2*i +: 2])
                              : vumw_pkg::CODE_DATA;
        assign lane_ctrl.mode = add_mode_reg;

        vumw_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (lane_ctrl),
            .step    (step),
            .set_row (set_row),
            .data    (ch[i]),
            .column  (column_word),
            .value   (lane_value[i]),
            .on      (lane_on[i]),
            .row_now (lane_row[i])
        );

        // merge: enable bit 3 is channel x
        assign res.value[i]              = lane_value[i];
        assign res.channel_enable[L-1-i] = lane_on[i];
        assign res.row_now[i]            = lane_row[i];
    end

    assign res.write_address = cur_address;

    vumw_out_buf u_out_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (step),
        .din   (res),
        .full  (buf_full),
        .valid (qw.valid),
        .ready (qw.ready),
        .dout  (res_out)
    );

    assign qw.write_address  = res_out.write_address;
    assign qw.out_x          = res_out.value[0];
    assign qw.out_y          = res_out.value[1];
    assign qw.out_z          = res_out.value[2];
    assign qw.out_w          = res_out.value[3];
    assign qw.channel_enable = res_out.channel_enable;
    assign qw.row_x_now      = res_out.row_now[0];
    assign qw.row_y_now      = res_out.row_now[1];
    assign qw.row_z_now      = res_out.row_now[2];
    assign qw.row_w_now      = res_out.row_now[3];

endmodule

`default_nettype wire

[rtl/vumw_lane.sv]
// one channel lane: code select, add mode and the channel's row word
`default_nettype none

module vumw_lane (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire vumw_pkg::lane_ctrl_t          ctrl,
    input  wire logic                          step,
    input  wire logic                          set_row,
    input  wire logic [vumw_pkg::WORD_W-1:0]   data,
    input  wire logic [vumw_pkg::WORD_W-1:0]   column,
    output logic      [vumw_pkg::WORD_W-1:0]   value,
    output logic                               on,
    output logic      [vumw_pkg::WORD_W-1:0]   row_now
);

    logic [vumw_pkg::WORD_W-1:0] row_reg;
    logic [vumw_pkg::WORD_W-1:0] row_next;
    logic [vumw_pkg::WORD_W-1:0] sum;

    assign sum = data + row_reg;

    always_comb
    begin
        value   = '0;
        on      = 1'b1;
        row_now = row_reg;
        case (ctrl.code)
            vumw_pkg::CODE_ROW:     value = row_reg;
            vumw_pkg::CODE_COLUMN:  value = column;
            vumw_pkg::CODE_PROTECT: on = 1'b0;
            default:
            begin
                case (ctrl.mode)
                    vumw_pkg::MODE_COPY:
                    begin
                        value   = data;
                        row_now = data;
                    end
                    vumw_pkg::MODE_OFFSET: value = sum;
                    vumw_pkg::MODE_ACCUM:
                    begin
                        value   = sum;
                        row_now = sum;
                    end
                    default: value = data;
                endcase
            end
        endcase
    end

    always_comb
    begin
        row_next = row_reg;
        if (set_row)
        begin
            row_next = data;
        end
        else if (step)
        begin
            row_next = row_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

[rtl/vumw_addr_seq.sv]
// quadword address and cycle counter with skip and fill handling
`default_nettype none

module vumw_addr_seq #(
    parameter int MEM_QWORDS = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire vumw_pkg::seq_ctrl_t           ctrl,
    input  wire logic [vumw_pkg::QADDR_W-1:0]  start_address,
    input  wire logic [7:0]                    cycle_cl,
    input  wire logic [7:0]                    cycle_wl,
    output logic      [vumw_pkg::QADDR_W-1:0]  cur_address,
    output logic      [1:0]                    row_sel
);

    localparam int AW = $clog2(MEM_QWORDS);
    localparam int TW = (AW + 1 > vumw_pkg::QADDR_W) ? AW + 1 : vumw_pkg::QADDR_W;
    localparam logic [TW-1:0] MEM_T = TW'(MEM_QWORDS);
    localparam int CW = vumw_pkg::CNT_W;

    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    logic [CW-1:0] wl_full;
    logic          fill;
    logic [CW-1:0] cyc;
    logic [CW-1:0] blk;
    logic          skip;
    logic [TW-1:0] skip_sum;
    logic [TW-1:0] addr0;
    logic [TW-1:0] inc_sum;
    logic [TW-1:0] inc_addr;
    logic [TW-1:0] start_mod;
    logic [CW-1:0] cnt0;
    logic [CW:0]   cnt1;

    always_comb
    begin
        wl_full = (cycle_wl == 8'd0) ? CW'(256) : CW'(cycle_wl);
        fill    = CW'(cycle_cl) < wl_full;
        cyc     = fill ? CW'(cycle_cl) : wl_full;
        blk     = fill ? wl_full : CW'(cycle_cl);
        skip    = !fill && (cnt_reg >= cyc);

        skip_sum = TW'(addr_reg) + TW'(blk - cyc);
        if (skip_sum >= MEM_T)
        begin
            skip_sum = skip_sum - MEM_T;
        end
        addr0 = skip ? skip_sum : TW'(addr_reg);

        inc_sum  = addr0 + TW'(1);
        inc_addr = (inc_sum >= MEM_T) ? inc_sum - MEM_T : inc_sum;

        cnt0 = skip ? '0 : cnt_reg;
        cnt1 = {1'b0, cnt0} + (CW+1)'(1);

        start_mod = TW'(start_address);
        for (int k = 0; k < 4; k++)
        begin
            if (start_mod >= MEM_T)
            begin
                start_mod = start_mod - MEM_T;
            end
        end

        addr_next = addr_reg;
        cnt_next  = cnt_reg;
        if (ctrl.start)
        begin
            addr_next = AW'(start_mod);
            cnt_next  = '0;
        end
        else if (ctrl.step)
        begin
            addr_next = AW'(inc_addr);
            cnt_next  = (cnt1 >= {1'b0, blk}) ? '0 : cnt1[CW-1:0];
        end
    end

    assign cur_address = addr0[vumw_pkg::QADDR_W-1:0];
    assign row_sel     = (cnt0 >= CW'(3)) ? 2'd3 : cnt0[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            addr_reg <= addr_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        TW'(addr_reg) < MEM_T)
        else $error("address register out of memory range");

    a_start_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> cnt_reg == '0)
        else $error("start did not clear cycle count");

    a_count_bounded_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && !ctrl.start) |=> cnt_reg < CW'(256))
        else $error("cycle count passed block bound");

endmodule

`default_nettype wire

[rtl/vumw_out_buf.sv]
// two-entry result buffer between the lanes and the write channel
`default_nettype none

module vumw_out_buf (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire vumw_pkg::result_t   din,
    output logic                     full,
    output logic                     valid,
    input  wire logic                ready,
    output vumw_pkg::result_t        dout
);

    vumw_pkg::result_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign full  = count_reg == 2'd2;
    assign valid = count_reg != 2'd0;
    assign pop   = valid && ready;
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count overflow");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("word pushed into full result buffer");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 2'd1)
        else $error("result buffer count did not drop on pop");

endmodule

`default_nettype wire

[tb/tb_vector_unpack_mask_mode_writer_unit.sv]
// self-checking testbench for the vector unpack mask/mode writer unit
`timescale 1ns / 100ps

module tb_vector_unpack_mask_mode_writer_unit;

    import vumw_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_LIMIT = 2000;

    typedef struct packed {
        logic [QADDR_W-1:0]           addr;
        logic [LANES-1:0][WORD_W-1:0] val;
        logic [LANES-1:0]             en;
        logic [LANES-1:0][WORD_W-1:0] row;
    } qword_write_t;

    logic                   clk;
    logic                   rst_n;
    logic                   wr_en;
    logic [REG_INDEX_W-1:0] reg_index;
    logic [WORD_W-1:0]      wr_data;

    vumw_vec_if vec ();
    vumw_qw_if  qw ();

    vector_unpack_mask_mode_writer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec       (vec),
        .qw        (qw),
        .wr_en     (wr_en),
        .reg_index (reg_index),
        .wr_data   (wr_data)
    );

    // predicted block state and configuration
    logic [WORD_W-1:0]            cfg_mask    = '0;
    logic                         cfg_mask_en = 1'b0;
    add_mode_t                    cfg_mode    = MODE_NONE;
    logic [7:0]                   cfg_cl      = 8'd1;
    logic [7:0]                   cfg_wl      = 8'd1;
    logic [LANES-1:0][WORD_W-1:0] row_words   = '0;
    logic [LANES-1:0][WORD_W-1:0] col_words   = '0;
    logic [QADDR_W-1:0]           next_qaddr  = '0;
    int                           row_count   = 0;

    qword_write_t pending_writes[$];
    qword_write_t got_write;
    int           mismatch_count = 0;
    int           sim_cycles = 0;
    int           stall_left = 0;
    int           hold_cnt = 0;
    bit           hold_armed = 1'b0;
    bit           quiet_run = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        sim_cycles++;
        if (sim_cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off when armed
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            qw.ready <= 1'b0;
            stall_left = 0;
            hold_cnt = 0;
        end
        else if (hold_armed && hold_cnt < HOLD_CYCLES)
        begin
            qw.ready <= 1'b0;
            hold_cnt++;
        end
        else
        begin
            if (!hold_armed)
                hold_cnt = 0;
            if (stall_left > 0)
            begin
                qw.ready <= 1'b0;
                stall_left--;
            end
            else if (!quiet_run && $urandom_range(0, 7) == 0)
            begin
                qw.ready <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end
            else
                qw.ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [WORD_W-1:0] e,
                                        logic [WORD_W-1:0] a);
        if (a !== e)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && qw.valid && qw.ready)
        begin
            if (pending_writes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected word expected none actual address %0h",
                         $time, qw.write_address);
            end
            else
            begin
                got_write = pending_writes.pop_front();
                check_field("write_address", WORD_W'(got_write.addr),
                            WORD_W'(qw.write_address));
                check_field("out_x", got_write.val[0], qw.out_x);
                check_field("out_y", got_write.val[1], qw.out_y);
                check_field("out_z", got_write.val[2], qw.out_z);
                check_field("out_w", got_write.val[3], qw.out_w);
                check_field("channel_enable", WORD_W'(got_write.en),
                            WORD_W'(qw.channel_enable));
                check_field("row_x_now", got_write.row[0], qw.row_x_now);
                check_field("row_y_now", got_write.row[1], qw.row_y_now);
                check_field("row_z_now", got_write.row[2], qw.row_z_now);
                check_field("row_w_now", got_write.row[3], qw.row_w_now);
            end
        end
    end

    function automatic logic [LANES-1:0][WORD_W-1:0] lanes4(logic [31:0] x, logic [31:0] y,
                                                             logic [31:0] z, logic [31:0] w);
        return {w, z, y, x};
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic predict_vector(cmd_t cmd, logic [QADDR_W-1:0] sa,
                                  logic [LANES-1:0][WORD_W-1:0] lanes);
        int           wl_len;
        int           cyc;
        int           blk;
        int           cc;
        bit           fill;
        logic [7:0]   mbyte;
        chan_code_t   code;
        logic [31:0]  v;
        qword_write_t w;
        case (cmd)
            CMD_SET_ROW: row_words = lanes;
            CMD_SET_COL: col_words = lanes;
            CMD_START:
            begin
                next_qaddr = sa;
                row_count = 0;
            end
            default:
            begin
                wl_len = (cfg_wl == 8'd0) ? 256 : int'(cfg_wl);
                fill = int'(cfg_cl) < wl_len;
                cyc = fill ? int'(cfg_cl) : wl_len;
                blk = fill ? wl_len : int'(cfg_cl);
                // skip the gap between write runs
                if (!fill && row_count >= cyc)
                begin
                    next_qaddr = next_qaddr + QADDR_W'(blk - cyc);
                    row_count = 0;
                end
                cc = (row_count < 3) ? row_count : 3;
                mbyte = cfg_mask[cc*8 +: 8];
                w.en = '0;
                for (int i = 0; i < LANES; i++)
                begin
                    code = cfg_mask_en ? chan_code_t'(mbyte[2*i +: 2]) : CODE_DATA;
                    v = '0;
                    case (code)
                        CODE_ROW:     v = row_words[i];
                        CODE_COLUMN:  v = col_words[cc];
                        CODE_PROTECT: v = '0;
                        default:
                        begin
                            v = lanes[i];
                            if (cfg_mode == MODE_COPY)
                                row_words[i] = v;
                            else if (cfg_mode != MODE_NONE)
                            begin
                                v = v + row_words[i];
                                if (cfg_mode == MODE_ACCUM)
                                    row_words[i] = v;
                            end
                        end
                    endcase
                    w.val[i] = v;
                    w.en[LANES-1-i] = (code != CODE_PROTECT);
                end
                w.addr = next_qaddr;
                w.row = row_words;
                pending_writes.push_back(w);
                next_qaddr = next_qaddr + 1'b1;
                row_count++;
                if (row_count >= blk)
                    row_count = 0;
            end
        endcase
    endtask

    task automatic send_vector(cmd_t cmd, logic [QADDR_W-1:0] sa,
                               logic [LANES-1:0][WORD_W-1:0] lanes);
        int gap;
        gap = (!quiet_run && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            vec.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vec.valid         <= 1'b1;
        vec.command       <= cmd;
        vec.start_address <= sa;
        vec.chan_x        <= lanes[0];
        vec.chan_y        <= lanes[1];
        vec.chan_z        <= lanes[2];
        vec.chan_w        <= lanes[3];
        @(posedge clk);
        while (!vec.ready)
            @(posedge clk);
        predict_vector(cmd, sa, lanes);
    endtask

    task automatic send_write(logic [LANES-1:0][WORD_W-1:0] lanes);
        send_vector(CMD_WRITE, QADDR_W'($urandom_range(0, 1023)), lanes);
    endtask

    task automatic wait_block_idle();
        int guard;
        guard = 0;
        vec.valid <= 1'b0;
        while (pending_writes.size() > 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [WORD_W-1:0] value);
        wr_en     <= 1'b1;
        reg_index <= idx;
        wr_data   <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_WRITE_MASK:  cfg_mask = value;
            REG_MASK_ENABLE: cfg_mask_en = value[0];
            REG_ADD_MODE:    cfg_mode = add_mode_t'(value[1:0]);
            REG_CYCLE_CL:    cfg_cl = value[7:0];
            REG_CYCLE_WL:    cfg_wl = value[7:0];
            default:         ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_cycle(logic [7:0] cl, logic [7:0] wl);
        write_reg(REG_CYCLE_CL, {24'd0, cl});
        write_reg(REG_CYCLE_WL, {24'd0, wl});
    endtask

    task automatic test_reset_defaults();
        send_write(lanes4(32'h0, 32'h0, 32'h0, 32'h0));
        send_write(lanes4(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        wait_block_idle();
    endtask

    task automatic test_codes_and_modes();
        set_cycle(8'd4, 8'd4);
        // row 0 mixed, row 1 all row, row 2 all column, row 3 all protected
        write_reg(REG_WRITE_MASK, 32'hffaa_55e4);
        write_reg(REG_MASK_ENABLE, 32'd1);
        write_reg(REG_ADD_MODE, {30'd0, MODE_OFFSET});
        send_vector(CMD_START, 10'd1022, lanes4(0, 0, 0, 0));
        send_vector(CMD_SET_ROW, 10'd0,
                    lanes4(32'hffff_ffff, 32'h1, 32'h8000_0000, 32'h1234_5678));
        send_vector(CMD_SET_COL, 10'h3ff,
                    lanes4(32'haaaa_aaaa, 32'h5555_5555, 32'hdead_beef, 32'h0000_4000));
        repeat (4) send_write(lanes4(32'h1, 32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff));
        wait_block_idle();
        write_reg(REG_WRITE_MASK, 32'h0);
        write_reg(REG_ADD_MODE, {30'd0, MODE_ACCUM});
        repeat (2) send_write(lanes4(32'hffff_ffff, 32'h7fff_ffff, 32'h1, 32'h8000_0000));
        wait_block_idle();
        write_reg(REG_ADD_MODE, {30'd0, MODE_COPY});
        send_write(lanes4(32'h0123_4567, 32'h89ab_cdef, 32'hffff_ffff, 32'h0));
        wait_block_idle();
    endtask

    task automatic test_skip_and_fill();
        write_reg(REG_ADD_MODE, {30'd0, MODE_NONE});
        write_reg(REG_MASK_ENABLE, 32'd0);
        set_cycle(8'd3, 8'd2);
        send_vector(CMD_START, 10'd5, lanes4(0, 0, 0, 0));
        repeat (3) send_write(lanes4($urandom, $urandom, $urandom, $urandom));
        wait_block_idle();
        set_cycle(8'd255, 8'd1);
        repeat (2) send_write(lanes4($urandom, $urandom, $urandom, $urandom));
        wait_block_idle();
        // fill with wl 0 standing for 256
        set_cycle(8'd0, 8'd0);
        repeat (2) send_write(lanes4($urandom, $urandom, $urandom, $urandom));
        wait_block_idle();
        // shrink the block, then shrink it again while the count is past the new bound
        set_cycle(8'd8, 8'd8);
        repeat (2) send_write(lanes4($urandom, $urandom, $urandom, $urandom));
        wait_block_idle();
        set_cycle(8'd2, 8'd1);
        send_write(lanes4($urandom, $urandom, $urandom, $urandom));
        wait_block_idle();
    endtask

    task automatic test_backpressure();
        write_reg(REG_WRITE_MASK, $urandom);
        write_reg(REG_MASK_ENABLE, 32'd1);
        write_reg(REG_ADD_MODE, {30'd0, MODE_ACCUM});
        set_cycle(8'd5, 8'd3);
        hold_armed <= 1'b1;
        repeat (24) send_write(lanes4(random_word(), random_word(), random_word(),
                                      random_word()));
        wait_block_idle();
        hold_armed <= 1'b0;
    endtask

    task automatic test_random_stream();
        int          pick;
        logic [7:0]  cl;
        logic [7:0]  wl;
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: begin cl = 8'd0;   wl = 8'd0;   end
                1: begin cl = 8'd255; wl = 8'd255; end
                2: begin cl = 8'd255; wl = 8'd1;   end
                3: begin cl = 8'd1;   wl = 8'd255; end
                default:
                begin
                    cl = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 6));
                    wl = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 6));
                end
            endcase
            if (phase == 8)
                quiet_run <= 1'b1;
            write_reg(REG_WRITE_MASK, (phase == 5) ? 32'hffff_ffff : $urandom);
            write_reg(REG_MASK_ENABLE, ($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0);
            write_reg(REG_ADD_MODE, $urandom_range(0, 3));
            set_cycle(cl, wl);
            for (int n = 0; n < 40; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_write(lanes4(random_word(), random_word(), random_word(),
                                      random_word()));
                else if (pick < 80)
                    send_vector(CMD_SET_ROW, QADDR_W'($urandom_range(0, 1023)),
                                lanes4(random_word(), random_word(), random_word(),
                                       random_word()));
                else if (pick < 90)
                    send_vector(CMD_SET_COL, QADDR_W'($urandom_range(0, 1023)),
                                lanes4(random_word(), random_word(), random_word(),
                                       random_word()));
                else
                    send_vector(CMD_START, QADDR_W'($urandom_range(0, 1023)),
                                lanes4(random_word(), random_word(), random_word(),
                                       random_word()));
            end
            wait_block_idle();
        end
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        wr_en             = 1'b0;
        reg_index         = '0;
        wr_data           = '0;
        vec.valid         = 1'b0;
        vec.command       = CMD_WRITE;
        vec.start_address = '0;
        vec.chan_x        = '0;
        vec.chan_y        = '0;
        vec.chan_z        = '0;
        vec.chan_w        = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_codes_and_modes();
        test_skip_and_fill();
        test_backpressure();
        test_random_stream();

        wait_block_idle();
        if (pending_writes.size() > 0)
        begin
            mismatch_count++;
            $display("%0t: leftover words expected 0 actual %0d",
                     $time, pending_writes.size());
        end
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/vumw_pkg.sv
rtl/vumw_if.sv
rtl/vumw_lane.sv
rtl/vumw_addr_seq.sv
rtl/vumw_out_buf.sv
rtl/vector_unpack_mask_mode_writer_unit.sv
tb/tb_vector_unpack_mask_mode_writer_unit.sv
